// ===== rtl/core/tgi_pkg.sv =====
`timescale 1ns / 1ps
// Package for the trilinear grid interpolator: field widths, command and
// register codes, fixed-point constants and the per-coordinate helpers.
// Depends on nothing; used by rtl/core/trilinear_grid_interpolator.sv.
package tgi_pkg;

	// Widths of the word fields on the ports.
	localparam int CMD_W  = 1;
	localparam int ADDR_W = 12;
	localparam int SMP_W  = 24;
	localparam int CRD_W  = 18;
	localparam int REG_W  = 5;
	localparam int IDX_W  = 2;

	// Internal datapath widths.
	localparam int RFL_W = 17;  // reflected coordinate, 0 to 1.0 in Q1.16
	localparam int WGT_W = 16;  // neighbour weight, at most one half
	localparam int CMP_W = 17;  // complementary weight, up to 1.0
	localparam int WXY_W = 33;  // product of two weights, up to 1.0 in Q1.32
	localparam int PRD_W = 42;  // one partial product
	localparam int ACC_W = 60;  // blend accumulator
	localparam int ZS_W  = 41;  // y blend after its rounding, Q.16

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_SIZE_Z = 2'd2;
	localparam logic [REG_W-1:0] SIZE_RESET = 5'd16;

	// Axis positions in the per-axis arrays.
	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;

	// Fixed-point constants.
	localparam logic signed [CRD_W:0] FIX_ONE_S = 19'sd65536;
	localparam logic signed [CRD_W:0] FIX_TWO_S = 19'sd131072;
	localparam logic [RFL_W-1:0] FIX_ONE_R = 17'h10000;
	localparam logic [CMP_W-1:0] FIX_ONE_W = 17'h10000;
	localparam logic [WGT_W-1:0] FIX_HALF_W = 16'h8000;
	localparam logic signed [ACC_W-1:0] RND16 = 60'sd32768;
	localparam logic signed [ACC_W-1:0] RND32 = 60'sd2147483648;
	localparam logic signed [ACC_W-1:0] SAT_HI = 60'sd8388607;
	localparam logic signed [ACC_W-1:0] SAT_LO = -60'sd8388608;

	// Mirror a coordinate once, about 0 if negative or about 1.0 if above it, then clamp to [0, 1.0].
	function automatic logic [RFL_W-1:0] reflect(input logic signed [CRD_W-1:0] c);
		logic signed [CRD_W:0] cx;
		logic signed [CRD_W:0] rr;
		cx = (CRD_W+1)'(c);
		if (cx < 0) begin
			rr = -cx;
		end else if (cx > FIX_ONE_S) begin
			rr = FIX_TWO_S - cx;
		end else begin
			rr = cx;
		end
		if (rr > FIX_ONE_S) begin
			return FIX_ONE_R;
		end
		return rr[RFL_W-1:0];
	endfunction

	// Saturate the rounded blend to the sample range.
	function automatic logic signed [SMP_W-1:0] saturate(input logic signed [ACC_W-1:0] v);
		if (v > SAT_HI) begin
			return SAT_HI[SMP_W-1:0];
		end
		if (v < SAT_LO) begin
			return SAT_LO[SMP_W-1:0];
		end
		return v[SMP_W-1:0];
	endfunction

endpackage

// ===== rtl/core/trilinear_grid_interpolator.sv =====
`timescale 1ns / 1ps
// Trilinear grid interpolator: grid memory, query sequencer and blend datapath.
// Depends on rtl/core/tgi_pkg.sv.

// The grid lives in one single-port synchronous memory of GRID_POINTS samples,
// loaded by write words (command 0) in row-major order with z fastest; the
// memory is not cleared, so every grid point a query touches must have been
// written first. A write word goes straight into memory. A query word holds
// off the next word until its result is loaded: the map and base states turn
// the coordinates into cells and weights, the run state feeds eight serial
// memory reads and the two z-blend terms through one shared pair of 24 by 17
// multipliers, the drain state empties that pipeline and the final state rounds
// and loads the result once the output register is free, where it waits while
// the next word is accepted. Size registers must be written only while the block
// is idle, which it does not enforce; size 0 acts as 1, above GRID_SIDE as GRID_SIDE.
module trilinear_grid_interpolator #(
	parameter int GRID_SIDE   = 16,
	parameter int GRID_POINTS = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port
	input  logic                                cfg_write,
	input  logic [tgi_pkg::IDX_W-1:0]           cfg_index,
	input  logic [tgi_pkg::REG_W-1:0]           cfg_data,
	// Item channel
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [tgi_pkg::CMD_W-1:0]           command,
	input  logic [tgi_pkg::ADDR_W-1:0]          sample_address,
	input  logic signed [tgi_pkg::SMP_W-1:0]    sample_value,
	input  logic signed [tgi_pkg::CRD_W-1:0]    coord_x,
	input  logic signed [tgi_pkg::CRD_W-1:0]    coord_y,
	input  logic signed [tgi_pkg::CRD_W-1:0]    coord_z,
	// Result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [tgi_pkg::SMP_W-1:0]    interpolated_value
);

	localparam int NW = $clog2(GRID_SIDE + 1);
	localparam int YW = 2 * NW;
	localparam int IW = 3 * NW;
	localparam int AW = $clog2(GRID_POINTS);

	// Sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MAP   = 3'd1;
	localparam logic [2:0] ST_BASE  = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	// Blend terms: eight grid samples, then the two z-blend terms.
	localparam logic [3:0] TERM_ZS0  = 4'd3;
	localparam logic [3:0] TERM_ZS1  = 4'd7;
	localparam logic [3:0] LAST_TERM = 4'd9;

	typedef struct packed {
		logic [NW-1:0]              c1;
		logic [NW-1:0]              c2;
		logic [tgi_pkg::WGT_W-1:0]  w;
	} axis_t;

	// Effective axis size: 0 acts as 1, large values act as GRID_SIDE.
	function automatic logic [NW-1:0] eff_size(input logic [tgi_pkg::REG_W-1:0] v);
		if (v == '0) begin
			return NW'(1);
		end
		if (32'(v) > 32'(GRID_SIDE)) begin
			return NW'(GRID_SIDE);
		end
		return NW'(v);
	endfunction

	// Cell, mirrored neighbour and neighbour weight for one axis.
	function automatic axis_t map_axis(input logic [tgi_pkg::RFL_W-1:0] r,
			input logic [NW-1:0] n);
		logic [15+NW:0] p;
		logic [NW-1:0]  ir;
		logic [15:0]    fr;
		logic           top;
		logic [NW-1:0]  i;
		axis_t          a;
		p   = (16+NW)'(r) * (16+NW)'(n);
		ir  = p[15+NW:16];
		fr  = p[15:0];
		top = (ir == n);
		i   = top ? n - NW'(1) : ir;
		a.c1 = i;
		if (top || fr[15]) begin
			a.c2 = (i + NW'(1) == n) ? i : i + NW'(1);
		end else begin
			a.c2 = (i == '0) ? i : i - NW'(1);
		end
		if (top) begin
			a.w = tgi_pkg::FIX_HALF_W;
		end else if (fr[15]) begin
			a.w = {1'b0, fr[14:0]};
		end else begin
			a.w = tgi_pkg::FIX_HALF_W - fr;
		end
		return a;
	endfunction

	// Registers
	logic [2:0]                        state_q;
	logic [3:0]                        cnt_q;
	logic [tgi_pkg::REG_W-1:0]         size_x_q, size_y_q, size_z_q;
	logic [tgi_pkg::RFL_W-1:0]         r_q [3];
	logic [NW-1:0]                     n_q [3];
	axis_t                             axis_q [3];
	logic [YW-1:0]                     nyz_q;
	logic [IW-1:0]                     xoff_q [2];
	logic [YW-1:0]                     yoff_q [2];
	logic [tgi_pkg::WXY_W-1:0]         wxy_q [4];
	logic signed [tgi_pkg::ACC_W-1:0]  acc_q;
	logic signed [tgi_pkg::ZS_W-1:0]   zs_q [2];
	logic                              result_valid_q;
	logic signed [tgi_pkg::SMP_W-1:0]  interpolated_value_q;

	// Pipeline registers of the blend datapath
	logic                              v_s1, v_s2;
	logic [3:0]                        cnt_s1, cnt_s2;
	logic                              oob_s1;
	logic signed [tgi_pkg::SMP_W-1:0]  rdata_s1;
	logic signed [tgi_pkg::PRD_W-1:0]  p_hi_s2, p_lo_s2;

	// Grid memory
	logic signed [tgi_pkg::SMP_W-1:0]  grid_mem [GRID_POINTS];

	// Combinational signals
	logic                              item_accept;
	logic                              query_accept;
	logic                              mem_we;
	logic [AW-1:0]                     waddr;
	logic                              rd_en;
	logic [IW-1:0]                     idx;
	logic                              oob;
	logic [AW-1:0]                     raddr;
	logic signed [tgi_pkg::SMP_W-1:0]  a_hi, a_lo;
	logic [tgi_pkg::CMP_W-1:0]         b_hi, b_lo;
	logic signed [tgi_pkg::PRD_W-1:0]  p_hi_d, p_lo_d;
	logic signed [tgi_pkg::ACC_W-1:0]  hi_ext;
	logic signed [tgi_pkg::ACC_W-1:0]  acc_sum;
	logic signed [tgi_pkg::SMP_W-1:0]  res_d;
	logic                              fin_load;
	logic [tgi_pkg::WXY_W-1:0]         wxy_d [4];

	// Handshake: items are taken only while the sequencer is idle.
	assign item_stall   = (state_q != ST_IDLE);
	assign item_accept  = item_valid && !item_stall;
	assign query_accept = item_accept && (command == tgi_pkg::CMD_QUERY);
	assign result_valid = result_valid_q;
	assign interpolated_value = interpolated_value_q;

	// Write words go straight into the memory; out-of-range addresses are dropped.
	assign mem_we = item_accept && (command == tgi_pkg::CMD_WRITE)
		&& (32'(sample_address) < 32'(GRID_POINTS));
	assign waddr  = AW'(sample_address);

	// Row-major read index for the current sample term.
	always_comb begin
		logic [NW-1:0] zc;
		zc  = cnt_q[2] ? axis_q[tgi_pkg::AX_Z].c2 : axis_q[tgi_pkg::AX_Z].c1;
		idx = xoff_q[cnt_q[0]] + IW'(yoff_q[cnt_q[1]]) + IW'(zc);
	end
	assign oob   = (32'(idx) >= 32'(GRID_POINTS));
	assign raddr = AW'(idx);
	assign rd_en = (state_q == ST_RUN) && !cnt_q[3];

	// Single-port memory; writes and reads are kept apart by the sequencer.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[waddr] <= sample_value;
		end
		if (rd_en) begin
			rdata_s1 <= grid_mem[raddr];
		end
	end

	// Pairwise products of the x and y weights.
	always_comb begin
		logic [tgi_pkg::CMP_W-1:0] wxf;
		logic [tgi_pkg::CMP_W-1:0] wyf;
		for (int j = 0; j < 4; j++) begin
			wxf = j[0] ? {1'b0, axis_q[tgi_pkg::AX_X].w}
				: tgi_pkg::FIX_ONE_W - {1'b0, axis_q[tgi_pkg::AX_X].w};
			wyf = j[1] ? {1'b0, axis_q[tgi_pkg::AX_Y].w}
				: tgi_pkg::FIX_ONE_W - {1'b0, axis_q[tgi_pkg::AX_Y].w};
			wxy_d[j] = tgi_pkg::WXY_W'({17'b0, wxf} * {17'b0, wyf});
		end
	end

	// Operand selection for the multiplier pair. A sample term splits its
	// weight product into high and low halves; a z term splits the y blend.
	always_comb begin
		logic [tgi_pkg::WXY_W-1:0]        wsel;
		logic signed [tgi_pkg::ZS_W-1:0]  zsel;
		logic [tgi_pkg::CMP_W-1:0]        bz;
		wsel = wxy_q[cnt_s1[1:0]];
		zsel = zs_q[cnt_s1[0]];
		bz   = cnt_s1[0] ? {1'b0, axis_q[tgi_pkg::AX_Z].w}
			: tgi_pkg::FIX_ONE_W - {1'b0, axis_q[tgi_pkg::AX_Z].w};
		if (!cnt_s1[3]) begin
			a_hi = oob_s1 ? '0 : rdata_s1;
			a_lo = oob_s1 ? '0 : rdata_s1;
			b_hi = wsel[32:16];
			b_lo = {1'b0, wsel[15:0]};
		end else begin
			a_hi = zsel[40:17];
			a_lo = $signed({7'b0, zsel[16:0]});
			b_hi = bz;
			b_lo = bz;
		end
		p_hi_d = a_hi * $signed({1'b0, b_hi});
		p_lo_d = a_lo * $signed({1'b0, b_lo});
	end

	// Recombine the two partial products and add into the accumulator.
	always_comb begin
		hi_ext  = tgi_pkg::ACC_W'(p_hi_s2);
		acc_sum = acc_q + (cnt_s2[3] ? (hi_ext <<< 17) : (hi_ext <<< 16))
			+ tgi_pkg::ACC_W'(p_lo_s2);
	end

	// Final rounding by 32 bits and saturation.
	assign res_d    = tgi_pkg::saturate((acc_q + tgi_pkg::RND32) >>> 32);
	assign fin_load = (state_q == ST_FIN) && (!result_valid_q || !result_stall);

	// Control: configuration, sequencer, pipeline valids and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q       <= tgi_pkg::SIZE_RESET;
			size_y_q       <= tgi_pkg::SIZE_RESET;
			size_z_q       <= tgi_pkg::SIZE_RESET;
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					tgi_pkg::REG_SIZE_X: size_x_q <= cfg_data;
					tgi_pkg::REG_SIZE_Y: size_y_q <= cfg_data;
					tgi_pkg::REG_SIZE_Z: size_z_q <= cfg_data;
					default: ;
				endcase
			end
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (query_accept) begin
						state_q <= ST_MAP;
					end
				end
				ST_MAP: state_q <= ST_BASE;
				ST_BASE: begin
					cnt_q   <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == LAST_TERM) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (v_s2 && (cnt_s2 == LAST_TERM)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fin_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		// Reflect the coordinates and take the effective sizes at acceptance.
		if (query_accept) begin
			r_q[tgi_pkg::AX_X] <= tgi_pkg::reflect(coord_x);
			r_q[tgi_pkg::AX_Y] <= tgi_pkg::reflect(coord_y);
			r_q[tgi_pkg::AX_Z] <= tgi_pkg::reflect(coord_z);
			n_q[tgi_pkg::AX_X] <= eff_size(size_x_q);
			n_q[tgi_pkg::AX_Y] <= eff_size(size_y_q);
			n_q[tgi_pkg::AX_Z] <= eff_size(size_z_q);
		end
		// Cells and weights per axis, and the size of one x plane.
		if (state_q == ST_MAP) begin
			for (int k = 0; k < 3; k++) begin
				axis_q[k] <= map_axis(r_q[k], n_q[k]);
			end
			nyz_q <= YW'(n_q[tgi_pkg::AX_Y]) * YW'(n_q[tgi_pkg::AX_Z]);
		end
		// Plane and row offsets and the weight products.
		if (state_q == ST_BASE) begin
			xoff_q[0] <= IW'(axis_q[tgi_pkg::AX_X].c1) * IW'(nyz_q);
			xoff_q[1] <= IW'(axis_q[tgi_pkg::AX_X].c2) * IW'(nyz_q);
			yoff_q[0] <= YW'(axis_q[tgi_pkg::AX_Y].c1) * YW'(n_q[tgi_pkg::AX_Z]);
			yoff_q[1] <= YW'(axis_q[tgi_pkg::AX_Y].c2) * YW'(n_q[tgi_pkg::AX_Z]);
			for (int j = 0; j < 4; j++) begin
				wxy_q[j] <= wxy_d[j];
			end
			acc_q <= '0;
		end
		// Issue stage and product stage.
		cnt_s1  <= cnt_q;
		oob_s1  <= oob;
		cnt_s2  <= cnt_s1;
		p_hi_s2 <= p_hi_d;
		p_lo_s2 <= p_lo_d;
		// Accumulate; the y blends are rounded by 16 bits as each completes.
		if (v_s2) begin
			case (cnt_s2)
				TERM_ZS0: begin
					zs_q[0] <= tgi_pkg::ZS_W'((acc_sum + tgi_pkg::RND16) >>> 16);
					acc_q   <= '0;
				end
				TERM_ZS1: begin
					zs_q[1] <= tgi_pkg::ZS_W'((acc_sum + tgi_pkg::RND16) >>> 16);
					acc_q   <= '0;
				end
				default: acc_q <= acc_sum;
			endcase
		end
		// Output register.
		if (fin_load) begin
			interpolated_value_q <= res_d;
		end
	end

	// A new result only appears after the final rounding step.
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside the final step");

	// No memory write while reads of a query are in flight.
	a_no_write_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !v_s1 && !v_s2)
		else $error("grid write overlaps a query read");

	// The term counter stays within the ten blend terms.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> cnt_q <= LAST_TERM)
		else $error("term counter out of range");

	// A held result is never overwritten by the next one.
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && result_valid && result_stall |=> state_q == ST_FIN)
		else $error("final step left while the result is still held");

	// Products only flow while a query is being worked on.
	a_s2_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> state_q == ST_RUN || state_q == ST_DRAIN)
		else $error("product stage active outside a query");

endmodule
